FILE: design/rrc_pkg.sv
// Shared types, constants and helpers for the rectangle raster canvas.
package rrc_pkg;

  localparam int MAX_SIDE_DEF = 512;
  localparam int CFG_W        = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int BYTE_W       = 8;
  localparam int FIX_W        = 20;
  localparam int PT_W         = 22;
  localparam int FRAC_W       = 8;
  localparam int SEL_W        = 9;
  localparam int KIND_W       = 2;

  localparam logic [BYTE_W-1:0]  CHAR_OUTLINE = 8'h72;
  localparam logic [BYTE_W-1:0]  CHAR_FILLED  = 8'h52;
  localparam logic signed [PT_W-1:0] ONE_UNIT = PT_W'(1 << FRAC_W);

  localparam logic [CFG_W-1:0]  CANVAS_W_RST = CFG_W'(1);
  localparam logic [CFG_W-1:0]  CANVAS_H_RST = CFG_W'(1);
  localparam logic [BYTE_W-1:0] BG_RST       = BYTE_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_W = 2'd0,
    REG_CANVAS_H = 2'd1,
    REG_BG_BYTE  = 2'd2
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_RDATA,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [PT_W-1:0] xl;
    logic signed [PT_W-1:0] xh;
    logic signed [PT_W-1:0] xl1;
    logic signed [PT_W-1:0] xh1;
    logic signed [PT_W-1:0] yl;
    logic signed [PT_W-1:0] yh;
    logic signed [PT_W-1:0] yl1;
    logic signed [PT_W-1:0] yh1;
  } bnd_t;

  typedef struct packed {
    logic border;
    logic inner;
  } hit_t;

  function automatic logic signed [PT_W-1:0] ext_pt(input logic signed [FIX_W-1:0] v);
    return {{(PT_W-FIX_W){v[FIX_W-1]}}, v};
  endfunction

endpackage

FILE: design/rrc_cmd_if.sv
// Command channel: valid/ready plus one command's fields.
interface rrc_cmd_if;
  import rrc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [BYTE_W-1:0]        shape_char;
  logic signed [FIX_W-1:0]  rect_x;
  logic signed [FIX_W-1:0]  rect_y;
  logic signed [FIX_W-1:0]  rect_w;
  logic signed [FIX_W-1:0]  rect_h;
  logic [BYTE_W-1:0]        paint_byte;
  logic [SEL_W-1:0]         pixel_col;
  logic [SEL_W-1:0]         pixel_row;

  modport source (
    output valid, kind, shape_char, rect_x, rect_y, rect_w, rect_h, paint_byte,
           pixel_col, pixel_row,
    input  ready
  );

  modport sink (
    input  valid, kind, shape_char, rect_x, rect_y, rect_w, rect_h, paint_byte,
           pixel_col, pixel_row,
    output ready
  );
endinterface

FILE: design/rrc_rsp_if.sv
// Result channel: valid/ready plus status and pixel byte.
interface rrc_rsp_if;
  import rrc_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [BYTE_W-1:0] pixel_value;

  modport source (output valid, status, pixel_value, input ready);
  modport sink   (input valid, status, pixel_value, output ready);
endinterface

FILE: design/rrc_classify.sv
// Shared per-pixel compare unit: classifies one pixel against the rectangle.
module rrc_classify #(
  parameter int COORD_W = 9
) (
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  input  rrc_pkg::bnd_t      bnd,
  output rrc_pkg::hit_t      hit
);
  import rrc_pkg::*;

  logic signed [PT_W-1:0] px;
  logic signed [PT_W-1:0] py;
  logic                   on_rect;
  logic                   near_edge;

  assign px = PT_W'({col, {FRAC_W{1'b0}}});
  assign py = PT_W'({row, {FRAC_W{1'b0}}});

  assign on_rect   = (px >= bnd.xl) && (px <= bnd.xh) && (py >= bnd.yl) && (py <= bnd.yh);
  assign near_edge = (px < bnd.xl1) || (px > bnd.xh1) || (py < bnd.yl1) || (py > bnd.yh1);

  assign hit.border = on_rect && near_edge;
  assign hit.inner  = on_rect && !near_edge;
endmodule

FILE: design/rrc_mem.sv
// Canvas byte store: one write port, one registered read port.
module rrc_mem #(
  parameter int ADDR_W = 18
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [rrc_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [rrc_pkg::BYTE_W-1:0] rdata
);
  import rrc_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: design/rectangle_raster_canvas.sv
// Rectangle raster canvas: command sequencer, canvas store and result register.
//
// Usage: commands arrive on in_ch (valid/ready), one result per command leaves
// on out_ch (valid/ready). Canvas size and background byte are set on the
// cfg_ write port, only while the block is idle: the user must keep to this,
// as the block itself does not enforce it. A clear or an accepted draw sweeps
// the canvas in use one pixel per cycle, row by row, through a single compare
// unit and the single memory write port, then enters the finishing state.
// A read steps through address, registered memory read and finish states; a
// rejected draw, an out-of-range read and an unused kind go straight to finish.
// One command is in flight at a time; in_ch.ready is high only when idle.
// A finished result sits in an output register; a new command may be taken
// while it waits, and that command's result waits in its finishing cycle
// until the register is free, so stalls on out_ch never drop a result.
// Reset (synchronous, rst_n low) returns to idle, drops any pending result
// and restores the configuration registers; canvas contents are undefined until cleared.
module rectangle_raster_canvas #(
  parameter int MAX_SIDE = rrc_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrc_pkg::CFG_W-1:0]     cfg_wdata,
  rrc_cmd_if.sink                       in_ch,
  rrc_rsp_if.source                     out_ch
);
  import rrc_pkg::*;

  localparam int COORD_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIZE_W  = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W  = 2 * COORD_W;

  logic [CFG_W-1:0]   canvas_w_r;
  logic [CFG_W-1:0]   canvas_h_r;
  logic [BYTE_W-1:0]  bg_r;

  logic [SIZE_W-1:0]  cw_use;
  logic [SIZE_W-1:0]  ch_use;

  state_t             state_r, state_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  bnd_t               bnd_r, bnd_nxt;
  logic               clear_r, clear_nxt;
  logic               filled_r, filled_nxt;
  logic [BYTE_W-1:0]  paint_r, paint_nxt;
  logic [ADDR_W-1:0]  raddr_r, raddr_nxt;
  logic               res_status_r, res_status_nxt;
  logic [BYTE_W-1:0]  res_pixel_r, res_pixel_nxt;
  logic               out_valid_r;
  logic               out_status_r;
  logic [BYTE_W-1:0]  out_pixel_r;

  logic               accept;
  logic               draw_bad;
  logic               read_in;
  logic               last_col;
  logic               last_px;
  logic               out_free;
  logic               load_out;
  logic               mem_we;
  logic               mem_re;
  logic [BYTE_W-1:0]  mem_wdata;
  logic [BYTE_W-1:0]  mem_rdata;
  hit_t               hit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= CANVAS_W_RST;
      canvas_h_r <= CANVAS_H_RST;
      bg_r       <= BG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CANVAS_W: canvas_w_r <= cfg_wdata;
        REG_CANVAS_H: canvas_h_r <= cfg_wdata;
        REG_BG_BYTE:  bg_r       <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (canvas_w_r == '0) begin
      cw_use = SIZE_W'(1);
    end else if ((CFG_W+1)'(canvas_w_r) > (CFG_W+1)'(MAX_SIDE)) begin
      cw_use = SIZE_W'(MAX_SIDE);
    end else begin
      cw_use = SIZE_W'(canvas_w_r);
    end
    if (canvas_h_r == '0) begin
      ch_use = SIZE_W'(1);
    end else if ((CFG_W+1)'(canvas_h_r) > (CFG_W+1)'(MAX_SIDE)) begin
      ch_use = SIZE_W'(MAX_SIDE);
    end else begin
      ch_use = SIZE_W'(canvas_h_r);
    end
  end

  rrc_classify #(.COORD_W(COORD_W)) u_classify (
    .col (col_r),
    .row (row_r),
    .bnd (bnd_r),
    .hit (hit)
  );

  rrc_mem #(.ADDR_W(ADDR_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({row_r, col_r}),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (raddr_r),
    .rdata (mem_rdata)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign draw_bad = (in_ch.rect_w <= 0) || (in_ch.rect_h <= 0) ||
                    ((in_ch.shape_char != CHAR_OUTLINE) && (in_ch.shape_char != CHAR_FILLED));
  assign read_in  = ((CFG_W+1)'(in_ch.pixel_col) < (CFG_W+1)'(cw_use)) &&
                    ((CFG_W+1)'(in_ch.pixel_row) < (CFG_W+1)'(ch_use));
  assign last_col = (SIZE_W'(col_r) + SIZE_W'(1)) == cw_use;
  assign last_px  = last_col && ((SIZE_W'(row_r) + SIZE_W'(1)) == ch_use);
  assign out_free = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.kind)
            KIND_CLEAR: state_nxt = ST_SWEEP;
            KIND_DRAW:  state_nxt = draw_bad ? ST_FINISH : ST_SWEEP;
            KIND_READ:  state_nxt = read_in ? ST_READ : ST_FINISH;
            default:    state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SWEEP:  state_nxt = last_px ? ST_FINISH : ST_SWEEP;
      ST_READ:   state_nxt = ST_RDATA;
      ST_RDATA:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = out_free ? ST_IDLE : ST_FINISH;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath next values
  always_comb begin
    in_ch.ready    = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    load_out       = 1'b0;
    mem_wdata      = clear_r ? bg_r : paint_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    bnd_nxt        = bnd_r;
    clear_nxt      = clear_r;
    filled_nxt     = filled_r;
    paint_nxt      = paint_r;
    raddr_nxt      = raddr_r;
    res_status_nxt = res_status_r;
    res_pixel_nxt  = res_pixel_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready    = 1'b1;
        col_nxt        = '0;
        row_nxt        = '0;
        clear_nxt      = (in_ch.kind == KIND_CLEAR);
        filled_nxt     = (in_ch.shape_char == CHAR_FILLED);
        paint_nxt      = in_ch.paint_byte;
        raddr_nxt      = {COORD_W'(in_ch.pixel_row), COORD_W'(in_ch.pixel_col)};
        res_status_nxt = (in_ch.kind == KIND_DRAW) && draw_bad;
        res_pixel_nxt  = '0;
        bnd_nxt.xl     = ext_pt(in_ch.rect_x);
        bnd_nxt.xh     = ext_pt(in_ch.rect_x) + ext_pt(in_ch.rect_w);
        bnd_nxt.xl1    = ext_pt(in_ch.rect_x) + ONE_UNIT;
        bnd_nxt.xh1    = ext_pt(in_ch.rect_x) + ext_pt(in_ch.rect_w) - ONE_UNIT;
        bnd_nxt.yl     = ext_pt(in_ch.rect_y);
        bnd_nxt.yh     = ext_pt(in_ch.rect_y) + ext_pt(in_ch.rect_h);
        bnd_nxt.yl1    = ext_pt(in_ch.rect_y) + ONE_UNIT;
        bnd_nxt.yh1    = ext_pt(in_ch.rect_y) + ext_pt(in_ch.rect_h) - ONE_UNIT;
      end
      ST_SWEEP: begin
        mem_we = clear_r || hit.border || (hit.inner && filled_r);
        if (last_col) begin
          col_nxt = '0;
          row_nxt = row_r + COORD_W'(1);
        end else begin
          col_nxt = col_r + COORD_W'(1);
        end
      end
      ST_READ:   mem_re = 1'b1;
      ST_RDATA:  res_pixel_nxt = mem_rdata;
      ST_FINISH: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    bnd_r        <= bnd_nxt;
    clear_r      <= clear_nxt;
    filled_r     <= filled_nxt;
    paint_r      <= paint_nxt;
    raddr_r      <= raddr_nxt;
    res_status_r <= res_status_nxt;
    res_pixel_r  <= res_pixel_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_pixel_r  <= res_pixel_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.pixel_value = out_pixel_r;

  a_we_only_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SWEEP))
    else $error("canvas written outside a sweep");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> ((SIZE_W'(col_r) < cw_use) && (SIZE_W'(row_r) < ch_use)))
    else $error("sweep counter beyond canvas in use");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result raised outside finishing cycle");

  a_read_data_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDATA) |-> ($past(state_r) == ST_READ))
    else $error("read data taken without a memory read");
endmodule

FILE: tb/sv/rectangle_raster_canvas_tb.sv
// Self-checking testbench for the rectangle raster canvas: predicted canvas, random handshakes.
`timescale 1ns / 1ps

module rectangle_raster_canvas_tb;
  import rrc_pkg::*;

  localparam int          CANVAS_SIDE = MAX_SIDE_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic [BYTE_W-1:0]       shape_char;
    logic signed [FIX_W-1:0] rect_x;
    logic signed [FIX_W-1:0] rect_y;
    logic signed [FIX_W-1:0] rect_w;
    logic signed [FIX_W-1:0] rect_h;
    logic [BYTE_W-1:0]       paint_byte;
    logic [SEL_W-1:0]        pixel_col;
    logic [SEL_W-1:0]        pixel_row;
  } canvas_cmd_t;

  typedef struct {
    logic              status;
    logic [BYTE_W-1:0] pixel_value;
  } canvas_rsp_t;

  class canvas_scoreboard;
    logic [BYTE_W-1:0] pixels [CANVAS_SIDE*CANVAS_SIDE];
    bit                painted [CANVAS_SIDE*CANVAS_SIDE];
    int                width_reg;
    int                height_reg;
    logic [BYTE_W-1:0] bg_reg;
    canvas_rsp_t       expected_rsps [$];
    int                errors;
    int                n_checked;
    int                n_rejected;
    int                kind_count [4];

    function new();
      width_reg  = int'(CANVAS_W_RST);
      height_reg = int'(CANVAS_H_RST);
      bg_reg     = BG_RST;
      errors     = 0;
      n_checked  = 0;
      n_rejected = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
      foreach (painted[i]) painted[i] = 1'b0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_CANVAS_W: width_reg  = int'(v);
        REG_CANVAS_H: height_reg = int'(v);
        REG_BG_BYTE:  bg_reg     = v[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function int clamp_side(int v);
      if (v < 1) return 1;
      if (v > CANVAS_SIDE) return CANVAS_SIDE;
      return v;
    endfunction

    function int cols_used();
      return clamp_side(width_reg);
    endfunction

    function int rows_used();
      return clamp_side(height_reg);
    endfunction

    function bit is_painted(int col, int row);
      return painted[row*CANVAS_SIDE + col];
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction

    function void note_command(canvas_cmd_t c);
      canvas_rsp_t             r;
      int                      cw, ch, addr;
      bit                      filled, on_border;
      logic signed [PT_W-1:0]  xs, ys, ws, hs, px, py;
      cw = cols_used();
      ch = rows_used();
      r.status      = 1'b0;
      r.pixel_value = '0;
      kind_count[c.kind]++;
      if (c.kind == KIND_CLEAR) begin
        for (int row = 0; row < ch; row++)
          for (int col = 0; col < cw; col++) begin
            pixels[row*CANVAS_SIDE + col]  = bg_reg;
            painted[row*CANVAS_SIDE + col] = 1'b1;
          end
      end else if (c.kind == KIND_DRAW) begin
        filled = (c.shape_char == CHAR_FILLED);
        if (c.rect_w <= 0 || c.rect_h <= 0 || (c.shape_char != CHAR_OUTLINE && !filled)) begin
          r.status = 1'b1;
          n_rejected++;
        end else begin
          xs = ext_pt(c.rect_x);
          ys = ext_pt(c.rect_y);
          ws = ext_pt(c.rect_w);
          hs = ext_pt(c.rect_h);
          for (int row = 0; row < ch; row++)
            for (int col = 0; col < cw; col++) begin
              px = PT_W'(col * (1 << FRAC_W));
              py = PT_W'(row * (1 << FRAC_W));
              if (px >= xs && px <= xs + ws && py >= ys && py <= ys + hs) begin
                on_border = (px - xs < ONE_UNIT) || (xs + ws - px < ONE_UNIT) ||
                            (py - ys < ONE_UNIT) || (ys + hs - py < ONE_UNIT);
                if (on_border || filled) begin
                  addr          = row*CANVAS_SIDE + col;
                  pixels[addr]  = c.paint_byte;
                  painted[addr] = 1'b1;
                end
              end
            end
        end
      end else if (c.kind == KIND_READ) begin
        if (c.pixel_col < cw && c.pixel_row < ch)
          r.pixel_value = pixels[int'(c.pixel_row)*CANVAS_SIDE + int'(c.pixel_col)];
      end
      expected_rsps.push_back(r);
    endfunction

    task report_mismatch(string what);
      if (errors < 40) $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic status, logic [BYTE_W-1:0] pixel_value);
      canvas_rsp_t e;
      n_checked++;
      if (expected_rsps.size() == 0) begin
        report_mismatch("result transaction with no command outstanding");
      end else begin
        e = expected_rsps.pop_front();
        if (status !== e.status)
          report_mismatch($sformatf("result %0d status %b, predicted %b",
                                    n_checked, status, e.status));
        if (pixel_value !== e.pixel_value)
          report_mismatch($sformatf("result %0d pixel 0x%02h, predicted 0x%02h",
                                    n_checked, pixel_value, e.pixel_value));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   send_gap_max;
  int                   recv_stall_max;
  bit                   hold_req;
  int unsigned          cycle_count = 0;
  int                   settings_used = 0;
  canvas_scoreboard     sb;

  rrc_cmd_if cmd_bus ();
  rrc_rsp_if rsp_bus ();

  rectangle_raster_canvas DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (cmd_bus.sink),
    .out_ch    (rsp_bus.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic canvas_cmd_t plain_cmd(logic [KIND_W-1:0] kind);
    canvas_cmd_t c;
    c.kind       = kind;
    c.shape_char = '0;
    c.rect_x     = '0;
    c.rect_y     = '0;
    c.rect_w     = '0;
    c.rect_h     = '0;
    c.paint_byte = '0;
    c.pixel_col  = '0;
    c.pixel_row  = '0;
    return c;
  endfunction

  function automatic canvas_cmd_t draw_cmd(logic [BYTE_W-1:0] shape,
                                           int x,
                                           int y,
                                           int w,
                                           int h,
                                           logic [BYTE_W-1:0] paint);
    canvas_cmd_t c;
    c            = plain_cmd(KIND_DRAW);
    c.shape_char = shape;
    c.rect_x     = FIX_W'(x);
    c.rect_y     = FIX_W'(y);
    c.rect_w     = FIX_W'(w);
    c.rect_h     = FIX_W'(h);
    c.paint_byte = paint;
    return c;
  endfunction

  function automatic canvas_cmd_t read_cmd(int col, int row);
    canvas_cmd_t c;
    c           = plain_cmd(KIND_READ);
    c.pixel_col = SEL_W'(col);
    c.pixel_row = SEL_W'(row);
    return c;
  endfunction

  // Q.8 value in [lo, hi]; a third of them are rounded down to a whole pixel, but not below lo
  function automatic int rand_fix(int lo, int hi);
    int v;
    v = lo + int'($urandom_range(0, hi - lo));
    if ($urandom_range(0, 2) == 0) v = v & ~255;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic int rand_side();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return 0;
    if (p < 15) return $urandom_range(17, 48);
    return $urandom_range(1, 16);
  endfunction

  function automatic canvas_cmd_t random_command();
    canvas_cmd_t c;
    int          p, cw, ch, sel;
    p  = $urandom_range(0, 99);
    cw = sb.cols_used();
    ch = sb.rows_used();
    if (p < 42) begin
      c = draw_cmd($urandom_range(0, 1) ? CHAR_FILLED : CHAR_OUTLINE,
                   rand_fix(-512, (cw + 1) * 256), rand_fix(-512, (ch + 1) * 256),
                   rand_fix(1, (cw + 2) * 256), rand_fix(1, (ch + 2) * 256),
                   BYTE_W'($urandom));
    end else if (p < 76) begin
      if ($urandom_range(0, 3) == 0)
        c = read_cmd($urandom_range(0, 511), $urandom_range(0, 511));
      else
        c = read_cmd($urandom_range(0, cw - 1), $urandom_range(0, ch - 1));
    end else if (p < 80) begin
      c = plain_cmd(KIND_CLEAR);
    end else if (p < 84) begin
      c = plain_cmd(KIND_SPARE);
    end else if (p < 90) begin
      c = draw_cmd($urandom_range(0, 1) ? CHAR_FILLED : CHAR_OUTLINE,
                   rand_fix(-512, cw * 256), rand_fix(-512, ch * 256),
                   rand_fix(1, cw * 256), rand_fix(1, ch * 256), BYTE_W'($urandom));
      sel = $urandom_range(0, 2);
      if (sel == 0) begin
        c.shape_char = BYTE_W'($urandom);
        if (c.shape_char == CHAR_OUTLINE || c.shape_char == CHAR_FILLED)
          c.shape_char = c.shape_char ^ 8'h01;
      end else if (sel == 1) begin
        c.rect_w = FIX_W'(rand_fix(-524288, 0));
      end else begin
        c.rect_h = FIX_W'(rand_fix(-524288, 0));
      end
    end else begin
      c.kind       = KIND_W'($urandom);
      c.shape_char = BYTE_W'($urandom);
      c.rect_x     = FIX_W'($urandom);
      c.rect_y     = FIX_W'($urandom);
      c.rect_w     = FIX_W'($urandom);
      c.rect_h     = FIX_W'($urandom);
      c.paint_byte = BYTE_W'($urandom);
      c.pixel_col  = SEL_W'($urandom);
      c.pixel_row  = SEL_W'($urandom);
    end
    return c;
  endfunction

  task automatic send_command(canvas_cmd_t c);
    int gap, tries;
    // never read a pixel that holds no defined value yet
    if (c.kind == KIND_READ) begin
      tries = 0;
      while (c.pixel_col < sb.cols_used() && c.pixel_row < sb.rows_used() &&
             !sb.is_painted(int'(c.pixel_col), int'(c.pixel_row)) && tries < 8) begin
        c.pixel_col = SEL_W'($urandom_range(0, sb.cols_used() - 1));
        c.pixel_row = SEL_W'($urandom_range(0, sb.rows_used() - 1));
        tries++;
      end
      if (c.pixel_col < sb.cols_used() && c.pixel_row < sb.rows_used() &&
          !sb.is_painted(int'(c.pixel_col), int'(c.pixel_row))) begin
        c.pixel_col = '0;
        c.pixel_row = '0;
      end
    end
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.kind       <= c.kind;
    cmd_bus.shape_char <= c.shape_char;
    cmd_bus.rect_x     <= c.rect_x;
    cmd_bus.rect_y     <= c.rect_y;
    cmd_bus.rect_w     <= c.rect_w;
    cmd_bus.rect_h     <= c.rect_h;
    cmd_bus.paint_byte <= c.paint_byte;
    cmd_bus.pixel_col  <= c.pixel_col;
    cmd_bus.pixel_row  <= c.pixel_row;
    do @(posedge clk); while (!cmd_bus.ready);
    sb.note_command(c);
  endtask

  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_canvas(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                                logic [CFG_W-1:0] bg);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CANVAS_W;
    cfg_wdata <= w;
    @(posedge clk);
    sb.write_reg(REG_CANVAS_W, w);
    cfg_index <= REG_CANVAS_H;
    cfg_wdata <= h;
    @(posedge clk);
    sb.write_reg(REG_CANVAS_H, h);
    cfg_index <= REG_BG_BYTE;
    cfg_wdata <= bg;
    @(posedge clk);
    sb.write_reg(REG_BG_BYTE, bg);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : result_sink
    int stall;
    rsp_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = $urandom_range(0, recv_stall_max);
      end
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      sb.check_result(rsp_bus.status, rsp_bus.pixel_value);
    end
  end

  initial begin : stimulus
    sb                 = new();
    hold_req           = 1'b0;
    send_gap_max       = 14;
    recv_stall_max     = 14;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_CANVAS_W;
    cfg_wdata          <= '0;
    cmd_bus.valid      <= 1'b0;
    cmd_bus.kind       <= KIND_CLEAR;
    cmd_bus.shape_char <= '0;
    cmd_bus.rect_x     <= '0;
    cmd_bus.rect_y     <= '0;
    cmd_bus.rect_w     <= '0;
    cmd_bus.rect_h     <= '0;
    cmd_bus.paint_byte <= '0;
    cmd_bus.pixel_col  <= '0;
    cmd_bus.pixel_row  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size is one pixel
    send_command(plain_cmd(KIND_CLEAR));
    send_command(read_cmd(0, 0));
    send_command(read_cmd(1, 0));
    send_command(plain_cmd(KIND_SPARE));

    program_canvas(10'd8, 10'd6, 10'hA5);
    send_command(plain_cmd(KIND_CLEAR));
    send_command(draw_cmd(CHAR_OUTLINE, 256, 256, 1280, 768, 8'h11));
    send_command(draw_cmd(CHAR_FILLED, -128, 576, 896, 704, 8'hEE));
    send_command(draw_cmd(CHAR_FILLED, -524288, 0, 524287, 524287, 8'h77));
    send_command(draw_cmd(CHAR_OUTLINE, 0, 0, 524287, 524287, 8'hFF));
    send_command(draw_cmd(CHAR_OUTLINE, 256, 256, 0, 512, 8'h33));
    send_command(draw_cmd(CHAR_FILLED, 256, 256, 512, -256, 8'h33));
    send_command(draw_cmd(8'h78, 256, 256, 512, 512, 8'h33));
    send_command(read_cmd(3, 1));
    send_command(read_cmd(7, 5));
    send_command(read_cmd(8, 0));
    send_command(read_cmd(0, 6));

    // resize without clearing: stored pixels stay where they were
    program_canvas(10'd12, 10'd4, 10'h5A);
    send_command(read_cmd(5, 2));
    send_command(draw_cmd(CHAR_FILLED, 2304, 0, 512, 768, 8'h42));
    send_command(read_cmd(10, 1));

    program_canvas(10'd0, 10'd1023, 10'h000);
    send_command(plain_cmd(KIND_CLEAR));
    send_command(read_cmd(0, 511));
    send_command(read_cmd(1, 0));

    program_canvas(10'd1023, 10'd0, 10'h0FF);
    send_command(draw_cmd(CHAR_FILLED, 0, 0, 511 * 256, 256, 8'h3C));
    send_command(read_cmd(511, 0));

    program_canvas(10'd512, 10'd512, 10'h0FF);
    send_command(plain_cmd(KIND_CLEAR));
    send_command(read_cmd(511, 511));

    for (int phase = 0; phase < 5; phase++) begin
      program_canvas(CFG_W'(rand_side()), CFG_W'(rand_side()), CFG_W'($urandom_range(0, 255)));
      send_gap_max   = (phase == 1 || phase == 3) ? 0 : 14;
      recv_stall_max = (phase == 1) ? 0 : 14;
      if (phase == 3) hold_req = 1'b1;
      if (phase != 2) send_command(plain_cmd(KIND_CLEAR));
      for (int n = 0; n < 15; n++) begin
        if (phase == 3) send_command(read_cmd(0, 0));
        else send_command(random_command());
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Run covered %0d clears, %0d draws (%0d rejected), %0d reads, %0d spare kinds",
             sb.kind_count[KIND_CLEAR], sb.kind_count[KIND_DRAW], sb.n_rejected,
             sb.kind_count[KIND_READ], sb.kind_count[KIND_SPARE]);
    $display("over %0d canvas settings; %0d results compared in %0d cycles",
             settings_used, sb.n_checked, cycle_count);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
